/* rtl/tpcf_pkg.sv */
// Package for the transparent pixel color fill block: widths, codes and helpers.
package tpcf_pkg;

    localparam int MAX_WIDTH_DEF  = 2048;
    localparam int MAX_HEIGHT_DEF = 2048;
    localparam int DIM_W          = 12;
    localparam int PIX_W          = 32;

    // Configuration register indexes
    localparam logic [0:0] REG_WIDTH  = 1'b0;
    localparam logic [0:0] REG_HEIGHT = 1'b1;

    // Window pixel: channel lanes
    function automatic logic [7:0] chan(input logic [PIX_W-1:0] p, input int k);
        chan = p[8*k +: 8];
    endfunction

endpackage

/* rtl/tpcf_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read.
module tpcf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

/* rtl/tpcf_div.sv */
// Iterative restoring divider: 11-bit channel sum by a neighbor count of 1..8.
module tpcf_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [10:0] num,
    input  logic [3:0]  den,
    output logic        busy,
    output logic [7:0]  quot
);
    logic [10:0] q_reg, q_next;
    logic [4:0]  rem_reg, rem_next;
    logic [3:0]  den_reg, den_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic [4:0]  trial;

    // One quotient bit per cycle, eleven quotient bits in all
    always_comb
    begin
        q_next   = q_reg;
        rem_next = rem_reg;
        den_next = den_reg;
        cnt_next = cnt_reg;
        trial    = {rem_reg[3:0], q_reg[10]};
        if (start)
        begin
            q_next   = num;
            rem_next = '0;
            den_next = den;
            cnt_next = 4'd11;
        end
        else if (cnt_reg != 4'd0)
        begin
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = trial - {1'b0, den_reg};
                q_next   = {q_reg[9:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                q_next   = {q_reg[9:0], 1'b0};
            end
            cnt_next = cnt_reg - 4'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign busy = (cnt_reg != 4'd0) || start;
    assign quot = q_reg[7:0];
endmodule

/* rtl/transparent_pixel_color_fill_top.sv */
// Top level of the transparent pixel color fill block.
// Transparent pixel color fill: RGBA8 pixels in raster order; a pixel with
// alpha zero gets the truncated average color of the opaque pixels of its
// 3x3 window (clipped at the edges). Two row memories hold the previous rows
// and are read in the cycle before their data is used. One item is handled at
// a time: an input item goes through accept, memory read, window load, six emit
// steps and counter update when none of its output pixels needs a fill. Each
// output pixel that needs a fill also waits on the iterative dividers (eleven
// quotient steps, the three channels divided in parallel) and their hand-back.
// Images narrower or shorter than 2 pass straight through (accept, read,
// counter update). A waiting output item that is not taken holds up the emit
// steps and the next accept. Output lags by one row plus one pixel; in the last
// row an input past the first column gives two pixels and the final input up
// to four, the last flagged with tlast. A configuration write restarts the image.
module transparent_pixel_color_fill_top #(
    parameter int MAX_WIDTH  = tpcf_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = tpcf_pkg::MAX_HEIGHT_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // config write
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [11:0] cfg_data,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // red, green, blue, alpha
    // output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // out_red, out_green, out_blue, out_alpha
    output logic        m_tlast    // last_pixel
);
    localparam int AW = $clog2(MAX_WIDTH);
    localparam int XW = $clog2(MAX_WIDTH + 1);
    localparam int YW = $clog2(MAX_HEIGHT + 1);
    localparam int PW = tpcf_pkg::PIX_W;

    typedef enum logic [2:0] {ST_IDLE, ST_READ, ST_PLAN, ST_EMIT, ST_DIV, ST_OUT}
        state_t;

    state_t state_reg;
    logic [11:0] wcfg_reg, hcfg_reg;
    logic [XW-1:0] w_eff, col_reg;
    logic [YW-1:0] h_eff, row_reg;
    logic [PW-1:0] px_reg, up_reg, mid_reg;
    logic [PW-1:0] win_reg [6];
    logic [2:0] step_reg;
    logic [PW-1:0] res_reg;
    logic last_reg, out_v_reg;
    logic [PW-1:0] up_rd, mid_rd;
    logic div_start;
    logic [10:0] sum_r, sum_g, sum_b;
    logic [7:0] q_r, q_g, q_b;
    logic bz_r, bz_g, bz_b;

    // Effective dimensions
    always_comb
    begin
        if (wcfg_reg == 12'd0) w_eff = XW'(1);
        else if (32'(wcfg_reg) > MAX_WIDTH) w_eff = XW'(MAX_WIDTH);
        else w_eff = XW'(wcfg_reg);
        if (hcfg_reg == 12'd0) h_eff = YW'(1);
        else if (32'(hcfg_reg) > MAX_HEIGHT) h_eff = YW'(MAX_HEIGHT);
        else h_eff = YW'(hcfg_reg);
    end

    logic narrow_img, final_in, last_row;
    assign narrow_img = (w_eff < XW'(2)) || (h_eff < YW'(2));
    assign final_in   = (col_reg == w_eff - XW'(1)) && (row_reg == h_eff - YW'(1));
    assign last_row   = (row_reg == h_eff - YW'(1));

    // Row memories
    logic mem_we;
    assign mem_we = (state_reg == ST_PLAN) && !narrow_img;
    tpcf_ram #(.WIDTH(PW), .DEPTH(MAX_WIDTH)) u_upper (
        .clk(clk), .we(mem_we), .waddr(col_reg[AW-1:0]), .wdata(mid_rd),
        .re(state_reg == ST_READ), .raddr(col_reg[AW-1:0]), .rdata(up_rd));
    tpcf_ram #(.WIDTH(PW), .DEPTH(MAX_WIDTH)) u_middle (
        .clk(clk), .we(mem_we), .waddr(col_reg[AW-1:0]), .wdata(px_reg),
        .re(state_reg == ST_READ), .raddr(col_reg[AW-1:0]), .rdata(mid_rd));

    // Window as 3x3: wc[c][r]
    logic [PW-1:0] wc [3][3];
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            wc[0][i] = win_reg[3+i];
            wc[1][i] = win_reg[i];
        end
        wc[2][0] = up_reg;
        wc[2][1] = mid_reg;
        wc[2][2] = px_reg;
    end

    // Which output this step is: valid flag, center column/row, clip masks, last
    logic       s_en, s_last;
    logic [1:0] s_cc, s_cr;
    logic [2:0] s_cv, s_rv;
    always_comb
    begin
        s_en = 1'b0; s_last = 1'b0; s_cc = 2'd1; s_cr = 2'd1;
        s_cv = 3'b000; s_rv = 3'b000;
        case (step_reg)
            3'd0:
            begin
                s_en = (col_reg == XW'(0)) && (row_reg >= YW'(2));
                s_cv = 3'b011;
                s_rv = {2'b11, row_reg >= YW'(3)};
            end
            3'd1:
            begin
                s_en = (col_reg >= XW'(1)) && (row_reg >= YW'(1));
                s_cv = {2'b11, col_reg >= XW'(2)};
                s_rv = {2'b11, row_reg >= YW'(2)};
            end
            3'd2:
            begin
                s_en = (col_reg >= XW'(1)) && (row_reg >= YW'(1)) && final_in;
                s_cc = 2'd2;
                s_cv = 3'b110;
                s_rv = {2'b11, row_reg >= YW'(2)};
            end
            3'd3:
            begin
                s_en = (col_reg >= XW'(1)) && (row_reg >= YW'(1)) && last_row;
                s_cr = 2'd2;
                s_cv = {2'b11, col_reg >= XW'(2)};
                s_rv = 3'b110;
            end
            3'd4:
            begin
                s_en = (col_reg >= XW'(1)) && (row_reg >= YW'(1)) && final_in;
                s_cc = 2'd2; s_cr = 2'd2; s_last = 1'b1;
                s_cv = 3'b110;
                s_rv = 3'b110;
            end
            default:
            begin
                s_en = 1'b0;
            end
        endcase
    end

    // Neighbor sums for this step
    logic [PW-1:0] center;
    logic [3:0] n_cnt;
    always_comb
    begin
        center = wc[s_cc][s_cr];
        sum_r = '0; sum_g = '0; sum_b = '0; n_cnt = '0;
        for (int c = 0; c < 3; c++)
        begin
            for (int r = 0; r < 3; r++)
            begin
                if (s_cv[c] && s_rv[r] && (wc[c][r][31:24] != 8'd0))
                begin
                    sum_r = sum_r + 11'(tpcf_pkg::chan(wc[c][r], 0));
                    sum_g = sum_g + 11'(tpcf_pkg::chan(wc[c][r], 1));
                    sum_b = sum_b + 11'(tpcf_pkg::chan(wc[c][r], 2));
                    n_cnt = n_cnt + 4'd1;
                end
            end
        end
    end

    logic needs_div;
    assign needs_div = (center[31:24] == 8'd0) && (n_cnt != 4'd0);
    assign div_start = (state_reg == ST_EMIT) && s_en && needs_div;

    tpcf_div u_div_r (.clk(clk), .rst_n(rst_n), .start(div_start), .num(sum_r),
        .den(n_cnt), .busy(bz_r), .quot(q_r));
    tpcf_div u_div_g (.clk(clk), .rst_n(rst_n), .start(div_start), .num(sum_g),
        .den(n_cnt), .busy(bz_g), .quot(q_g));
    tpcf_div u_div_b (.clk(clk), .rst_n(rst_n), .start(div_start), .num(sum_b),
        .den(n_cnt), .busy(bz_b), .quot(q_b));

    assign cfg_ready = (state_reg == ST_IDLE) && !out_v_reg;
    assign s_tready  = (state_reg == ST_IDLE) && !out_v_reg && !cfg_valid;
    assign m_tvalid  = out_v_reg;
    assign m_tdata   = res_reg;
    assign m_tlast   = last_reg;

    // An output item is loaded this cycle
    logic out_load;
    assign out_load = ((state_reg == ST_READ) && narrow_img)
        || ((state_reg == ST_EMIT) && (!out_v_reg || m_tready) && s_en && !needs_div)
        || ((state_reg == ST_DIV) && !bz_r && !bz_g && !bz_b);

    logic [XW-1:0] col_inc;
    assign col_inc = col_reg + XW'(1);

    // Sequencer, counters and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            wcfg_reg  <= 12'd2048;
            hcfg_reg  <= 12'd2048;
            col_reg   <= '0;
            row_reg   <= '0;
            out_v_reg <= 1'b0;
            step_reg  <= '0;
            for (int i = 0; i < 6; i++) win_reg[i] <= '0;
        end
        else
        begin
            if (out_load) out_v_reg <= 1'b1;
            else if (m_tready) out_v_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (cfg_valid && cfg_ready)
                    begin
                        if (cfg_index == tpcf_pkg::REG_WIDTH) wcfg_reg <= cfg_data;
                        else hcfg_reg <= cfg_data;
                        col_reg <= '0;
                        row_reg <= '0;
                    end
                    else if (s_tvalid && s_tready)
                    begin
                        px_reg <= s_tdata;
                        if (col_reg >= w_eff || row_reg >= h_eff)
                        begin
                            col_reg <= '0;
                            row_reg <= '0;
                        end
                        state_reg <= ST_READ;
                    end
                end
                ST_READ:
                begin
                    if (narrow_img)
                    begin
                        res_reg   <= px_reg;
                        last_reg  <= final_in;
                        state_reg <= ST_OUT;
                    end
                    else
                    begin
                        state_reg <= ST_PLAN;
                    end
                end
                ST_PLAN:
                begin
                    up_reg    <= up_rd;
                    mid_reg   <= mid_rd;
                    step_reg  <= '0;
                    state_reg <= ST_EMIT;
                end
                ST_EMIT:
                begin
                    if (!out_v_reg || m_tready)
                    begin
                        if (step_reg == 3'd5)
                        begin
                            for (int i = 0; i < 3; i++)
                            begin
                                win_reg[3+i] <= win_reg[i];
                                win_reg[i]   <= wc[2][i];
                            end
                            state_reg <= ST_OUT;
                        end
                        else if (!s_en)
                        begin
                            step_reg <= step_reg + 3'd1;
                        end
                        else if (needs_div)
                        begin
                            res_reg   <= center;
                            last_reg  <= s_last;
                            state_reg <= ST_DIV;
                        end
                        else
                        begin
                            res_reg   <= center;
                            last_reg  <= s_last;
                            step_reg  <= step_reg + 3'd1;
                        end
                    end
                end
                ST_DIV:
                begin
                    if (!bz_r && !bz_g && !bz_b)
                    begin
                        res_reg   <= {res_reg[31:24], q_b, q_g, q_r};
                        step_reg  <= step_reg + 3'd1;
                        state_reg <= ST_EMIT;
                    end
                end
                ST_OUT:
                begin
                    if (col_inc >= w_eff)
                    begin
                        col_reg <= '0;
                        row_reg <= (row_reg + YW'(1) >= h_eff) ? '0 : row_reg + YW'(1);
                    end
                    else
                    begin
                        col_reg <= col_inc;
                    end
                    state_reg <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end
endmodule

/* rtl/tpcf_checker.sv */
// Port-level checker for the transparent pixel color fill block, with its bind.
module tpcf_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        cfg_valid,
    input logic        cfg_ready,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        m_tlast
);
    // A stalled output item holds its data
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output changed while stalled");

    // No input accepted while an output item waits
    a_no_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !s_tready)
        else $error("input taken while output pending");

    // Input and config never accepted together
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && s_tvalid && cfg_valid && cfg_ready))
        else $error("input and config accepted together");

    // An accepted input blocks the next cycle
    a_seq: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("back-to-back input accept");
endmodule

bind transparent_pixel_color_fill_top tpcf_checker u_tpcf_checker (
    .clk(clk), .rst_n(rst_n), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .m_tvalid(m_tvalid),
    .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast));

/* test/transparent_pixel_color_fill_top_tb.sv */
// Testbench for the transparent pixel color fill block: stream stimulus, predictor, checker.
`timescale 1ns / 100ps

module transparent_pixel_color_fill_top_tb;

    localparam int MAXW       = tpcf_pkg::MAX_WIDTH_DEF;
    localparam int MAXH       = tpcf_pkg::MAX_HEIGHT_DEF;
    localparam int QUIET_WAIT = 40;
    localparam int STALL_LIM  = 5000;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [0:0]  cfg_index;
    logic [11:0] cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;   // red, green, blue, alpha
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // out_red, out_green, out_blue, out_alpha
    logic        m_tlast;   // last_pixel

    transparent_pixel_color_fill_top DUT (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready),
        .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    // Pixels waiting to be sent, and filled pixels waiting to come out ({last, rgba})
    logic [31:0] pixel_q[$];
    logic [32:0] filled_q[$];

    // Predictor state
    logic [31:0] upper_row[MAXW];
    logic [31:0] middle_row[MAXW];
    logic [31:0] left_cols[6];
    int unsigned col_pos, row_pos;
    logic [11:0] width_reg, height_reg;

    int  errors;
    int  pixels_in, pixels_out, cfg_writes;
    int  send_idle, recv_idle;
    bit  hold_send;
    bit  pixel_taken;
    int  quiet_cycles;
    bit  done;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic int unsigned clip_dim(logic [11:0] v, int unsigned lim);
        if (v == 0)
            return 1;
        if (v > lim)
            return lim;
        return v;
    endfunction

    // Average of the opaque pixels in the clipped window, win index = col*3 + row
    function automatic logic [31:0] bleed(logic [31:0] win[9], bit cv[3], bit rv[3],
                                          int cc, int cr);
        logic [31:0] ctr;
        int unsigned sr, sg, sb, n;
        ctr = win[cc*3 + cr];
        sr = 0; sg = 0; sb = 0; n = 0;
        if (ctr[31:24] != 0)
            return ctr;
        for (int c = 0; c < 3; c++)
            for (int r = 0; r < 3; r++)
                if (cv[c] && rv[r] && win[c*3 + r][31:24] != 0)
                begin
                    sr += win[c*3 + r][7:0];
                    sg += win[c*3 + r][15:8];
                    sb += win[c*3 + r][23:16];
                    n++;
                end
        if (n == 0)
            return ctr;
        return {ctr[31:24], 8'(sb / n), 8'(sg / n), 8'(sr / n)};
    endfunction

    // Work out the filled pixels that one input pixel releases
    task automatic predict_fill(logic [31:0] px);
        int unsigned w, h, x, r;
        bit final_px;
        logic [31:0] win[9];
        bit cv[3], rv[3];
        w = clip_dim(width_reg, MAXW);
        h = clip_dim(height_reg, MAXH);
        if (col_pos >= w || row_pos >= h)
        begin
            col_pos = 0;
            row_pos = 0;
        end
        x = col_pos;
        r = row_pos;
        final_px = (x == w - 1) && (r == h - 1);
        if (w < 2 || h < 2)
            filled_q.push_back({final_px, px});
        else
        begin
            for (int i = 0; i < 3; i++)
            begin
                win[i]     = left_cols[3 + i];
                win[3 + i] = left_cols[i];
            end
            win[6] = upper_row[x];
            win[7] = middle_row[x];
            win[8] = px;
            // first column of a row releases the end of the row two above
            if (x == 0 && r >= 2)
            begin
                cv = '{1, 1, 0};
                rv = '{r >= 3, 1, 1};
                filled_q.push_back({1'b0, bleed(win, cv, rv, 1, 1)});
            end
            if (x >= 1 && r >= 1)
            begin
                cv = '{x >= 2, 1, 1};
                rv = '{r >= 2, 1, 1};
                filled_q.push_back({1'b0, bleed(win, cv, rv, 1, 1)});
                if (final_px)
                begin
                    cv[0] = 0;
                    filled_q.push_back({1'b0, bleed(win, cv, rv, 2, 1)});
                end
                // bottom row also releases its own left neighbor
                if (r == h - 1)
                begin
                    cv[0] = (x >= 2);
                    rv[0] = 0;
                    filled_q.push_back({1'b0, bleed(win, cv, rv, 1, 2)});
                    if (final_px)
                    begin
                        cv[0] = 0;
                        filled_q.push_back({1'b1, bleed(win, cv, rv, 2, 2)});
                    end
                end
            end
            for (int i = 0; i < 3; i++)
            begin
                left_cols[3 + i] = left_cols[i];
                left_cols[i]     = win[6 + i];
            end
            upper_row[x]  = win[7];
            middle_row[x] = px;
        end
        x++;
        if (x >= w)
        begin
            x = 0;
            r++;
            if (r >= h)
                r = 0;
        end
        col_pos = x;
        row_pos = r;
    endtask

    // Monitor: accepted items on all three channels, output check, watchdog
    always @(posedge clk)
    begin
        pixel_taken = 1'b0;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == tpcf_pkg::REG_WIDTH)
                    width_reg = cfg_data;
                else
                    height_reg = cfg_data;
                col_pos = 0;
                row_pos = 0;
                cfg_writes++;
            end
            if (s_tvalid && s_tready)
            begin
                pixel_taken = 1'b1;
                pixels_in++;
                predict_fill(s_tdata);
            end
            if (m_tvalid && m_tready)
            begin
                pixels_out++;
                if (filled_q.size() == 0)
                begin
                    $error("output pixel %h with nothing expected", m_tdata);
                    errors++;
                end
                else
                begin
                    logic [32:0] want;
                    want = filled_q.pop_front();
                    if (m_tdata[7:0] != want[7:0])
                    begin
                        $error("out_red: expected %0d, got %0d", want[7:0], m_tdata[7:0]);
                        errors++;
                    end
                    if (m_tdata[15:8] != want[15:8])
                    begin
                        $error("out_green: expected %0d, got %0d", want[15:8], m_tdata[15:8]);
                        errors++;
                    end
                    if (m_tdata[23:16] != want[23:16])
                    begin
                        $error("out_blue: expected %0d, got %0d", want[23:16], m_tdata[23:16]);
                        errors++;
                    end
                    if (m_tdata[31:24] != want[31:24])
                    begin
                        $error("out_alpha: expected %0d, got %0d", want[31:24], m_tdata[31:24]);
                        errors++;
                    end
                    if (m_tlast != want[32])
                    begin
                        $error("last_pixel: expected %0d, got %0d", want[32], m_tlast);
                        errors++;
                    end
                end
            end
            if ((cfg_valid && cfg_ready) || (s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIM && !done)
            begin
                $display("timeout: %0d cycles without a transfer", quiet_cycles);
                $display("transparent_pixel_color_fill_top_tb NOT OK");
                $finish;
            end
        end
    end

    // Driver: pixel stream and receiver backpressure, changed on the falling edge
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!s_tvalid || pixel_taken)
            begin
                if (pixel_q.size() > 0 && !hold_send && $urandom_range(99) >= send_idle)
                begin
                    s_tdata  <= pixel_q.pop_front();
                    s_tvalid <= 1'b1;
                end
                else
                    s_tvalid <= 1'b0;
            end
            m_tready <= ($urandom_range(99) >= recv_idle);
        end
    end

    // Wait until the block has drained, then let it settle
    task automatic drain_quiet();
        while (pixel_q.size() > 0 || s_tvalid || filled_q.size() > 0)
            @(posedge clk);
        repeat (QUIET_WAIT) @(posedge clk);
    endtask

    task automatic write_reg(logic [0:0] idx, logic [11:0] val);
        @(negedge clk);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_size(logic [11:0] w, logic [11:0] h);
        drain_quiet();
        write_reg(tpcf_pkg::REG_WIDTH, w);
        write_reg(tpcf_pkg::REG_HEIGHT, h);
    endtask

    function automatic logic [31:0] rand_pixel();
        logic [31:0] p;
        p = $urandom;
        case ($urandom_range(3))
            0, 1: p[31:24] = 8'd0;
            2:    p[31:24] = 8'hFF;
            default: ;
        endcase
        return p;
    endfunction

    // Stimulus
    initial
    begin
        int w, h, n, k;
        rst_n = 1'b0;
        cfg_valid = 1'b0; cfg_index = tpcf_pkg::REG_WIDTH; cfg_data = '0;
        s_tvalid = 1'b0; s_tdata = '0; m_tready = 1'b0;
        width_reg = 12'd2048; height_reg = 12'd2048;
        col_pos = 0; row_pos = 0;
        foreach (left_cols[i]) left_cols[i] = '0;
        errors = 0; pixels_in = 0; pixels_out = 0; cfg_writes = 0;
        quiet_cycles = 0; done = 1'b0; hold_send = 1'b0;
        send_idle = 0; recv_idle = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset size: a few pixels, nothing comes out yet
        pixel_q.push_back(32'hFFFF_FFFF);
        pixel_q.push_back(32'h0000_0000);
        pixel_q.push_back(32'h00FF_00FF);
        // Zero width acts as one: pass-through
        set_size(12'd0, 12'd3);
        pixel_q.push_back(32'h0012_3456);
        pixel_q.push_back(32'hFF00_FF00);
        pixel_q.push_back(32'h00FF_FFFF);
        // Height one: pass-through, wraps into a second image
        set_size(12'd3, 12'd1);
        repeat (4) pixel_q.push_back(rand_pixel());
        // Oversized registers clip to the maximum
        set_size(12'hFFF, 12'hFFF);
        repeat (3) pixel_q.push_back(rand_pixel());
        // Smallest full window image: final pixel releases four
        set_size(12'd2, 12'd2);
        pixel_q.push_back(32'hFF10_2030);
        pixel_q.push_back(32'h0000_0000);
        pixel_q.push_back(32'h0000_0000);
        pixel_q.push_back(32'h01FF_FFFF);
        // 3x3: opaque extremes around a transparent center, and a lone transparent corner
        set_size(12'd3, 12'd3);
        pixel_q.push_back(32'hFFFF_FFFF);
        pixel_q.push_back(32'h8000_0000);
        pixel_q.push_back(32'h0000_0000);
        pixel_q.push_back(32'h0100_00FF);
        pixel_q.push_back(32'h00AB_CDEF);
        pixel_q.push_back(32'h0000_0000);
        pixel_q.push_back(32'h0000_0000);
        pixel_q.push_back(32'h0000_0000);
        pixel_q.push_back(32'h0000_0000);

        // Random images; idle pattern changes by thirds
        n = 0;
        while (n < 135)
        begin
            if (n < 45)
            begin
                send_idle = 8; recv_idle = 48;
            end
            else if (n < 90)
            begin
                send_idle = 48; recv_idle = 8;
            end
            else
            begin
                send_idle = 0; recv_idle = 0;
            end
            if ($urandom_range(9) == 0)
            begin
                w = 1; h = $urandom_range(1, 4);
            end
            else
            begin
                w = $urandom_range(2, 7); h = $urandom_range(2, 6);
            end
            set_size(12'(w), 12'(h));
            // queue a full image at once and drain it, then a partial image
            if ($urandom_range(3) == 0)
            begin
                hold_send = 1'b1;
                repeat (w * h) pixel_q.push_back(rand_pixel());
                n += w * h;
                hold_send = 1'b0;
                drain_quiet();
                hold_send = 1'b1;
                k = $urandom_range(1, w * h);
                repeat (k) pixel_q.push_back(rand_pixel());
                n += k;
                hold_send = 1'b0;
            end
            else
            begin
                k = $urandom_range(1, 2) * w * h;
                repeat (k) pixel_q.push_back(rand_pixel());
                n += k;
            end
        end
        send_idle = 0; recv_idle = 0;

        while (pixel_q.size() > 0 || s_tvalid || filled_q.size() > 0)
            @(posedge clk);
        repeat (QUIET_WAIT) @(posedge clk);
        done = 1'b1;
        $display("covered %0d pixels in, %0d pixels out, %0d register writes",
                 pixels_in, pixels_out, cfg_writes);
        $display("sizes from pass-through to clipped maximum, full and partial images");
        if (errors == 0 && filled_q.size() == 0)
            $display("transparent_pixel_color_fill_top_tb OK");
        else
            $display("transparent_pixel_color_fill_top_tb NOT OK");
        $finish;
    end

endmodule
